@@ src/page_frame_bitmap_allocator_unit_defines.svh @@
// Assertion macros for the page frame bitmap allocator.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PFBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pfba_pkg.sv @@
// Types, constants and helper functions of the page frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfba_pkg;

   localparam int DIRECTORY_ENTRIES = 4;
   localparam int FRAMES_PER_TABLE  = 1024;
   localparam int RESERVED_TOP      = 32'h201;
   localparam int MAP_WORDS         = 64;
   localparam int WORD_BITS         = 64;
   localparam int MAP_BITS          = MAP_WORDS * WORD_BITS;
   localparam int FRAME_COUNT       = (DIRECTORY_ENTRIES * FRAMES_PER_TABLE > MAP_BITS) ?
                                      MAP_BITS : DIRECTORY_ENTRIES * FRAMES_PER_TABLE;
   localparam int ADDR_W            = $clog2(MAP_WORDS);
   localparam int BIT_W             = $clog2(WORD_BITS);
   localparam int FRAME_W           = 12;
   localparam int STATUS_W          = 2;

   typedef logic [FRAME_W-1:0]   frame_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [BIT_W-1:0]     bit_idx_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic       valid;
      frame_type  frame_out;
      status_type status;
   } res_type;

   // Contents of a map word right after reset: low frames of table 0 are reserved.
   function automatic word_type reset_word(addr_type w);
      word_type v;
      int       f;
      v = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         f    = int'(w) * WORD_BITS + b;
         v[b] = (f < FRAME_COUNT) && (f < FRAMES_PER_TABLE) &&
                (f <= RESERVED_TOP + DIRECTORY_ENTRIES);
      end
      return v;
   endfunction

   // Bits of a word that name real frames.
   function automatic word_type live_mask(addr_type w);
      word_type v;
      int       f;
      v = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         f    = int'(w) * WORD_BITS + b;
         v[b] = (f < FRAME_COUNT);
      end
      return v;
   endfunction

   // Isolate the lowest set bit.
   function automatic word_type lowest_one(word_type x);
      return x & (~x + word_type'(1));
   endfunction

   function automatic bit_idx_type encode_onehot(word_type oh);
      bit_idx_type idx;
      idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         idx = idx | (oh[b] ? BIT_W'(b) : '0);
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

@@ src/pfba_channels.sv @@
// Request and response channel interfaces of the page frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pfba_req_if;
   import pfba_pkg::*;
   logic      valid;
   logic      ready;
   logic      op;
   frame_type frame;

   modport source (output valid, output op, output frame, input ready);
   modport sink   (input valid, input op, input frame, output ready);
endinterface

interface pfba_rsp_if;
   import pfba_pkg::*;
   logic                valid;
   logic                ready;
   frame_type           frame_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output frame_out, output status, input ready);
   modport sink   (input valid, input frame_out, input status, output ready);
endinterface
`default_nettype wire

@@ src/pfba_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pfba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/pfba_engine.sv @@
// Allocate/free sequencer: scans the used map word by word and writes back.
`timescale 1ns / 1ps
`default_nettype none
module pfba_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_op,
   input  wire pfba_pkg::frame_type  req_frame,
   output      logic                 req_ready,
   input  wire logic                 res_ready,
   output      pfba_pkg::res_type    res,
   output      pfba_pkg::mem_req_type mem,
   input  wire pfba_pkg::word_type   rd_data
);
   import pfba_pkg::*;

   state_type            state_ff, state_in;
   addr_type             addr_ff, addr_in;
   bit_idx_type          bit_ff, bit_in;
   frame_type            frame_out_ff, frame_out_in;
   status_type           status_ff, status_in;
   logic [MAP_WORDS-1:0] init_ff, init_in;

   logic        accept;
   logic        out_of_range;
   logic        last_word;
   word_type    eff_word;
   word_type    free_bits;
   word_type    pick;
   logic        found;
   bit_idx_type pick_idx;

   assign accept       = req_valid && (state_ff == ST_IDLE);
   assign out_of_range = ({1'b0, req_frame} >= (FRAME_W + 1)'(FRAME_COUNT));
   assign last_word    = (addr_ff == addr_type'(MAP_WORDS - 1));

   // A word never written still holds its reset contents.
   assign eff_word  = init_ff[addr_ff] ? rd_data : reset_word(addr_ff);
   assign free_bits = ~eff_word & live_mask(addr_ff);
   assign found     = |free_bits;
   assign pick      = lowest_one(free_bits);
   assign pick_idx  = encode_onehot(pick);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_FREE) begin
                  state_in = out_of_range ? ST_RESP : ST_FREE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (found || last_word) begin
               state_in = ST_RESP;
            end
         end
         ST_FREE: state_in = ST_RESP;
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mem          = '0;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      frame_out_in = frame_out_ff;
      status_in    = status_ff;
      init_in      = init_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               frame_out_in = '0;
               status_in    = STATUS_OK;
               bit_in       = req_frame[BIT_W-1:0];
               if (req_op == OP_FREE) begin
                  if (out_of_range) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     mem.rd_en   = 1'b1;
                     mem.rd_addr = req_frame[FRAME_W-1:BIT_W];
                     addr_in     = req_frame[FRAME_W-1:BIT_W];
                  end
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = '0;
                  addr_in     = '0;
               end
            end
         end
         ST_SCAN: begin
            if (found) begin
               mem.wr_en         = 1'b1;
               mem.wr_addr       = addr_ff;
               mem.wr_data       = eff_word | pick;
               init_in[addr_ff]  = 1'b1;
               frame_out_in      = {addr_ff, pick_idx};
               status_in         = STATUS_OK;
            end else if (last_word) begin
               frame_out_in = '0;
               status_in    = STATUS_EXHAUSTED;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = addr_ff + addr_type'(1);
               addr_in     = addr_ff + addr_type'(1);
            end
         end
         ST_FREE: begin
            mem.wr_en        = 1'b1;
            mem.wr_addr      = addr_ff;
            mem.wr_data      = eff_word & ~(word_type'(1) << bit_ff);
            init_in[addr_ff] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         init_ff  <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      bit_ff       <= bit_in;
      frame_out_ff <= frame_out_in;
      status_ff    <= status_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign res.valid     = (state_ff == ST_RESP);
   assign res.frame_out = frame_out_ff;
   assign res.status    = status_ff;

endmodule
`default_nettype wire

@@ src/page_frame_bitmap_allocator_unit.sv @@
// Top level of the page frame bitmap allocator: map RAM, sequencer, response register.
//
//   channel  dir  handshake         payload
//   req_ch   in   valid/ready       op, frame
//   rsp_ch   out  valid/ready       frame_out, status
//
// An allocate reads k map words (1..64) between accept and response,
// one word per cycle through the single read port of the map RAM.
// A free reads its map word and writes it back; an out-of-range free touches no map word.
// Reset is synchronous; per-word valid bits give the reserved low frames, so no clearing pass.
// A new request is taken once the previous one has moved into the response register,
// even while that beat waits on rsp_ch.ready.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_bitmap_allocator_unit_defines.svh"
module page_frame_bitmap_allocator_unit (
   input wire logic clock,
   input wire logic reset,
   pfba_req_if.sink   req_ch,
   pfba_rsp_if.source rsp_ch
);
   import pfba_pkg::*;

   mem_req_type mem;
   word_type    rd_data;
   res_type     res;
   logic        res_ready;
   logic        req_ready;

   logic        rsp_valid_ff, rsp_valid_in;
   frame_type   rsp_frame_ff, rsp_frame_in;
   status_type  rsp_status_ff, rsp_status_in;

   pfba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data)
   );

   pfba_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_frame (req_ch.frame),
      .req_ready (req_ready),
      .res_ready (res_ready),
      .res       (res),
      .mem       (mem),
      .rd_data   (rd_data)
   );

   assign req_ch.ready = req_ready;
   assign res_ready    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_frame_in  = res.frame_out;
         rsp_status_in = res.status;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.frame_out = rsp_frame_ff;
   assign rsp_ch.status    = rsp_status_ff;

   `PFBA_ASSERT_IMP(a_no_rw_collision, clock, reset, mem.rd_en && mem.wr_en, mem.rd_addr != mem.wr_addr, "map read and write hit the same word")
   `PFBA_ASSERT_IMP(a_zero_frame_on_error, clock, reset, rsp_ch.valid && (rsp_ch.status != STATUS_OK), rsp_ch.frame_out == '0, "nonzero frame on error status")
   `PFBA_ASSERT_IMP(a_ready_only_when_drained, clock, reset, req_ch.ready, !res.valid && !mem.wr_en, "request taken while previous one in flight")
   `PFBA_ASSERT_NEXT(a_result_reaches_port, clock, reset, res.valid && res_ready, rsp_ch.valid, "finished result did not reach response register")

endmodule
`default_nettype wire
